// File: design/smmh_pkg.sv
`timescale 1ns / 1ps

package smmh_pkg;

   localparam int CAPACITY    = 1022;
   localparam int FIRST_SLOT  = 2;
   localparam int DATA_W      = 32;
   localparam int COUNT_W     = $clog2(CAPACITY + 1);
   // at least three address bits so that the parent pair of slot 4 can be formed
   localparam int ADDR_W      = ($clog2(CAPACITY + FIRST_SLOT) < 3) ? 3
                                : $clog2(CAPACITY + FIRST_SLOT);
   localparam int STORE_DEPTH = 1 << ADDR_W;
   localparam int RSP_COUNT_W = 10;

   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_DELETE = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      status_type                 status;
      logic signed [DATA_W-1:0]   removed;
      logic signed [DATA_W-1:0]   cur_min;
      logic signed [DATA_W-1:0]   cur_max;
      logic [COUNT_W-1:0]         count;
   } rsp_type;

endpackage

// File: design/symmetric_min_max_heap.sv
`timescale 1ns / 1ps

// channel   ports                                            handshake
// request   req_type, req_value                              start while busy low
// response  rsp_status, rsp_removed_value, rsp_current_min,  rsp_valid, one cycle
//           rsp_current_max, rsp_element_count
//
// Busy time: a rejected request only reads back the minimum and maximum. An insert
// climbs level by level. A delete that empties the heap does no sift; any other delete
// descends level by level and then may climb. The response word shows in the same
// cycle that busy falls. The busy time is set by the single read port of the heap RAM
// and the one comparator. Reset (synchronous) empties the heap at once; RAM contents
// are left as they are. The response strobe cannot be stalled; a new request may be
// taken while it shows.

module symmetric_min_max_heap (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic                                    req_type,
   input  logic signed [smmh_pkg::DATA_W-1:0]      req_value,
   output logic                                    rsp_valid,
   output logic [1:0]                              rsp_status,
   output logic signed [smmh_pkg::DATA_W-1:0]      rsp_removed_value,
   output logic signed [smmh_pkg::DATA_W-1:0]      rsp_current_min,
   output logic signed [smmh_pkg::DATA_W-1:0]      rsp_current_max,
   output logic [smmh_pkg::RSP_COUNT_W-1:0]        rsp_element_count
);

   localparam int CW  = smmh_pkg::COUNT_W;
   localparam int RCW = smmh_pkg::RSP_COUNT_W;

   logic                              done;
   smmh_pkg::rsp_type                 rsp;
   logic                              wr_en;
   logic [smmh_pkg::ADDR_W-1:0]       wr_addr;
   logic [smmh_pkg::DATA_W-1:0]       wr_data;
   logic [smmh_pkg::ADDR_W-1:0]       rd_addr;
   logic [smmh_pkg::DATA_W-1:0]       rd_data;

   logic                              rsp_valid_ff;
   smmh_pkg::rsp_type                 rsp_ff;
   logic [CW+RCW-1:0]                 count_ext;

   smmh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_type  (req_type),
      .req_value (req_value),
      .busy      (busy),
      .done      (done),
      .rsp       (rsp),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   smmh_ram #(
      .WIDTH (smmh_pkg::DATA_W),
      .DEPTH (smmh_pkg::STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= done;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_ff <= rsp;
      end
   end

   assign count_ext = {{RCW{1'b0}}, rsp_ff.count};

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_ff.status;
   assign rsp_removed_value = rsp_ff.removed;
   assign rsp_current_min   = rsp_ff.cur_min;
   assign rsp_current_max   = rsp_ff.cur_max;
   assign rsp_element_count = count_ext[RCW-1:0];

`ifndef SYNTH
   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not start the sequencer");

   a_rsp_after_busy : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("response word without a request in progress");

   a_min_le_max : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_element_count != '0) |-> (rsp_current_min <= rsp_current_max))
      else $error("reported minimum above reported maximum");

   a_empty_reject : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == smmh_pkg::STATUS_EMPTY) |-> (rsp_element_count == '0))
      else $error("delete rejected on a non-empty heap");
`endif

endmodule

// File: design/smmh_ram.sv
`timescale 1ns / 1ps

module smmh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/smmh_ctrl.sv
`timescale 1ns / 1ps

module smmh_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic                              req_type,
   input  logic signed [smmh_pkg::DATA_W-1:0] req_value,
   output logic                              busy,
   output logic                              done,
   output smmh_pkg::rsp_type                 rsp,
   output logic                              wr_en,
   output logic [smmh_pkg::ADDR_W-1:0]       wr_addr,
   output logic [smmh_pkg::DATA_W-1:0]       wr_data,
   output logic [smmh_pkg::ADDR_W-1:0]       rd_addr,
   input  logic [smmh_pkg::DATA_W-1:0]       rd_data
);

   localparam int AW = smmh_pkg::ADDR_W;
   localparam int DW = smmh_pkg::DATA_W;
   localparam int CW = smmh_pkg::COUNT_W;

   typedef enum logic [15:0] {
      S_IDLE     = 16'b0000_0000_0000_0001,
      S_INS_SIB  = 16'b0000_0000_0000_0010,
      S_UP_RD    = 16'b0000_0000_0000_0100,
      S_UP_HI    = 16'b0000_0000_0000_1000,
      S_UP_LO    = 16'b0000_0000_0001_0000,
      S_WR_FIN   = 16'b0000_0000_0010_0000,
      S_DEL_RM   = 16'b0000_0000_0100_0000,
      S_DEL_LAST = 16'b0000_0000_1000_0000,
      S_SD_C1    = 16'b0000_0001_0000_0000,
      S_SD_C2    = 16'b0000_0010_0000_0000,
      S_SD_SEL   = 16'b0000_0100_0000_0000,
      S_SD_CHK   = 16'b0000_1000_0000_0000,
      S_SD_SIB   = 16'b0001_0000_0000_0000,
      S_RD_MIN   = 16'b0010_0000_0000_0000,
      S_RD_MAX   = 16'b0100_0000_0000_0000,
      S_RD_DONE  = 16'b1000_0000_0000_0000
   } state_type;

   state_type               state_ff, state_in;
   logic [CW-1:0]           count_ff, count_in;
   logic signed [DW-1:0]    cur_ff, cur_in;
   logic [AW-1:0]           idx_ff, idx_in;
   logic signed [DW-1:0]    tv_ff, tv_in;
   logic [AW-1:0]           t_ff, t_in;
   logic signed [DW-1:0]    removed_ff, removed_in;
   logic signed [DW-1:0]    min_ff, min_in;
   smmh_pkg::status_type    status_ff, status_in;

   logic signed [DW-1:0]    rd_val;
   logic signed [DW-1:0]    op_a, op_b;
   logic                    lt;
   logic [AW:0]             end_w;
   logic [AW:0]             c1_w, c2_w, tp1_w;
   logic [AW-1:0]           hi_addr, lo_addr;

   assign rd_val = rd_data;

   // the one comparator, operands steered by the sequencer
   assign lt = op_a < op_b;

   assign end_w   = {{(AW + 1 - CW){1'b0}}, count_ff} + (AW + 1)'(smmh_pkg::FIRST_SLOT);
   assign c1_w    = {idx_ff, 1'b0};
   assign c2_w    = c1_w + (AW + 1)'(2);
   assign tp1_w   = {1'b0, t_ff} + (AW + 1)'(1);
   assign hi_addr = {1'b0, idx_ff[AW-1:2], 1'b1};
   assign lo_addr = {1'b0, idx_ff[AW-1:2], 1'b0};

   always_comb begin
      op_a = rd_val;
      op_b = cur_ff;
      case (state_ff)
         S_INS_SIB, S_UP_LO: begin
            op_a = cur_ff;
            op_b = rd_val;
         end
         S_SD_SEL: begin
            op_a = rd_val;
            op_b = tv_ff;
         end
         S_SD_CHK: begin
            op_a = tv_ff;
            op_b = cur_ff;
         end
         default: begin
            op_a = rd_val;
            op_b = cur_ff;
         end
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      cur_in     = cur_ff;
      idx_in     = idx_ff;
      tv_in      = tv_ff;
      t_in       = t_ff;
      removed_in = removed_ff;
      min_in     = min_ff;
      status_in  = status_ff;
      wr_en      = 1'b0;
      wr_addr    = idx_ff;
      wr_data    = rd_data;
      rd_addr    = '0;
      done       = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               removed_in = '0;
               status_in  = smmh_pkg::STATUS_OK;
               case (req_type)
                  smmh_pkg::REQ_INSERT: begin
                     if (count_ff >= CW'(smmh_pkg::CAPACITY)) begin
                        status_in = smmh_pkg::STATUS_FULL;
                        state_in  = S_RD_MIN;
                     end else begin
                        cur_in   = req_value;
                        idx_in   = end_w[AW-1:0];
                        count_in = count_ff + CW'(1);
                        // an odd slot first settles against its left sibling
                        if (end_w[0]) begin
                           rd_addr  = end_w[AW-1:0] - AW'(1);
                           state_in = S_INS_SIB;
                        end else begin
                           state_in = S_UP_RD;
                        end
                     end
                  end
                  smmh_pkg::REQ_DELETE: begin
                     if (count_ff == '0) begin
                        status_in = smmh_pkg::STATUS_EMPTY;
                        state_in  = S_RD_MIN;
                     end else begin
                        rd_addr  = AW'(smmh_pkg::FIRST_SLOT);
                        count_in = count_ff - CW'(1);
                        state_in = S_DEL_RM;
                     end
                  end
                  default: begin
                     state_in = S_RD_MIN;
                  end
               endcase
            end
         end

         S_INS_SIB: begin
            if (lt) begin
               wr_en  = 1'b1;
               idx_in = idx_ff - AW'(1);
            end
            state_in = S_UP_RD;
         end

         S_UP_RD: begin
            if (idx_ff >= AW'(2 * smmh_pkg::FIRST_SLOT)) begin
               rd_addr  = hi_addr;
               state_in = S_UP_HI;
            end else begin
               state_in = S_WR_FIN;
            end
         end

         S_UP_HI: begin
            if (lt) begin
               wr_en    = 1'b1;
               idx_in   = hi_addr;
               state_in = S_UP_RD;
            end else begin
               rd_addr  = lo_addr;
               state_in = S_UP_LO;
            end
         end

         S_UP_LO: begin
            if (lt) begin
               wr_en    = 1'b1;
               idx_in   = lo_addr;
               state_in = S_UP_RD;
            end else begin
               state_in = S_WR_FIN;
            end
         end

         S_WR_FIN: begin
            wr_en    = 1'b1;
            wr_data  = cur_ff;
            state_in = S_RD_MIN;
         end

         S_DEL_RM: begin
            removed_in = rd_val;
            if (count_ff == '0) begin
               state_in = S_RD_MIN;
            end else begin
               // count already lowered: the old last slot sits at the new end
               rd_addr  = end_w[AW-1:0];
               state_in = S_DEL_LAST;
            end
         end

         S_DEL_LAST: begin
            cur_in   = rd_val;
            idx_in   = AW'(smmh_pkg::FIRST_SLOT);
            state_in = S_SD_C1;
         end

         S_SD_C1: begin
            if (c1_w >= end_w) begin
               state_in = S_UP_RD;
            end else begin
               rd_addr  = c1_w[AW-1:0];
               state_in = S_SD_C2;
            end
         end

         S_SD_C2: begin
            tv_in = rd_val;
            t_in  = c1_w[AW-1:0];
            if (c2_w < end_w) begin
               rd_addr  = c2_w[AW-1:0];
               state_in = S_SD_SEL;
            end else begin
               state_in = S_SD_CHK;
            end
         end

         S_SD_SEL: begin
            if (lt) begin
               tv_in = rd_val;
               t_in  = c2_w[AW-1:0];
            end
            state_in = S_SD_CHK;
         end

         S_SD_CHK: begin
            if (lt) begin
               wr_en   = 1'b1;
               wr_data = tv_ff;
               idx_in  = t_ff;
               if (tp1_w < end_w) begin
                  rd_addr  = tp1_w[AW-1:0];
                  state_in = S_SD_SIB;
               end else begin
                  state_in = S_SD_C1;
               end
            end else begin
               state_in = S_UP_RD;
            end
         end

         S_SD_SIB: begin
            // smaller right sibling: the moving word goes right, the sibling
            // takes over the hole and carries on down
            if (lt) begin
               wr_en   = 1'b1;
               wr_addr = idx_ff + AW'(1);
               wr_data = cur_ff;
               cur_in  = rd_val;
            end
            state_in = S_SD_C1;
         end

         S_RD_MIN: begin
            rd_addr  = AW'(smmh_pkg::FIRST_SLOT);
            state_in = S_RD_MAX;
         end

         S_RD_MAX: begin
            min_in   = (count_ff != '0) ? rd_val : '0;
            rd_addr  = AW'(smmh_pkg::FIRST_SLOT + 1);
            state_in = S_RD_DONE;
         end

         S_RD_DONE: begin
            done     = 1'b1;
            state_in = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp.status  = status_ff;
      rsp.removed = removed_ff;
      rsp.cur_min = min_ff;
      rsp.cur_max = (count_ff > CW'(1)) ? rd_val : min_ff;
      rsp.count   = count_ff;
   end

   assign busy = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff     <= cur_in;
      idx_ff     <= idx_in;
      tv_ff      <= tv_in;
      t_ff       <= t_in;
      removed_ff <= removed_in;
      min_ff     <= min_in;
      status_ff  <= status_in;
   end

endmodule
